// File: rtl/kts_pkg.sv
// Shared types, defaults and helpers for the key-to-slot allocator.
package kts_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int EYES_DEFAULT  = 3;
    localparam int KEY_W         = 64;
    localparam int MASK_W        = 3;
    localparam int EYE_IDX_W     = 2;
    localparam int SLOT_OUT_W    = 6;
    localparam int COMB_OUT_W    = 8;

    typedef struct packed {
        logic give_id;
        logic present;
        logic full;
        logic missing;
    } kts_flags_t;

    function automatic logic [EYE_IDX_W-1:0] eye_index(input logic [MASK_W-1:0] mask);
        logic [EYE_IDX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < MASK_W; b++)
        begin
            if (mask[b])
            begin
                idx = EYE_IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kts_ram
    import kts_pkg::*;
#(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kts_ctrl.sv
// Scan sequencer: one key compare per cycle over the used slots, then update.
module kts_ctrl
    import kts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic                     op,
    input  logic [KEY_W-1:0]         key,
    output logic                     busy,
    output logic                     res_valid,
    output logic [$clog2(SLOTS)-1:0] res_slot,
    output kts_flags_t               res_flags
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HW_W   = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HW_W-1:0]   iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic [HW_W-1:0]   hw_reg, hw_next;

    logic              rd_en;
    logic [KEY_W-1:0]  rd_data;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;

    kts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (iss_reg[SLOT_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        hw_next       = hw_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        res_valid     = 1'b0;
        res_slot      = '0;
        res_flags     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    op_next   = op;
                    key_next  = key;
                    iss_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    state_next = (key == '0) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_en     = iss_reg < hw_reg;
                pend_next = rd_en;
                pidx_next = iss_reg[SLOT_W-1:0];
                if (rd_en)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (pend_reg && rd_data == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pidx_reg;
                    state_next   = ST_FIN;
                end
                else
                begin
                    if (pend_reg && rd_data == '0)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (!pend_reg && !rd_en)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                res_valid  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg)
                begin
                    if (hit_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = hit_idx_reg;
                        res_slot          = hit_idx_reg;
                        res_flags.present = 1'b1;
                    end
                    else
                    begin
                        res_flags.missing = 1'b1;
                    end
                end
                else
                begin
                    priority if (key_reg == '0)
                    begin
                        res_flags.full = 1'b1;
                    end
                    else if (hit_reg)
                    begin
                        res_slot          = hit_idx_reg;
                        res_flags.present = 1'b1;
                        res_flags.give_id = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx_reg;
                        wr_data           = key_reg;
                        res_slot          = free_idx_reg;
                        res_flags.give_id = 1'b1;
                    end
                    else if (hw_reg < HW_W'(SLOTS))
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = hw_reg[SLOT_W-1:0];
                        wr_data           = key_reg;
                        res_slot          = hw_reg[SLOT_W-1:0];
                        res_flags.give_id = 1'b1;
                        hw_next           = hw_reg + 1'b1;
                    end
                    else
                    begin
                        res_flags.full = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            hw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            hw_reg    <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        iss_reg      <= iss_next;
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
    end

    assign busy = state_reg != ST_IDLE;

endmodule

// File: rtl/key_to_slot_id_allocator.sv
// Top level of the key-to-slot allocator: command port, sequencer and result register.
//
// Usage: drive opcode, key and eye_mask and raise start while busy is low; the
// command beat is taken at that clock edge. opcode 0 looks up a key, or places
// a new key in the highest empty slot below the high-water mark, else at the
// mark. opcode 1 releases the slot that holds the key.
// One result beat per command appears on slot_id, combined_id, was_present,
// table_full and release_missing, marked by done for exactly one cycle. The
// receiver cannot hold it off; the beat must be taken when done is high.
// Flow: an accepted command scans the slots below the high-water mark in order,
// stopping at the first match, then finishes and registers the result; a zero
// key skips the scan.
// The cost is one key compare per cycle against the slot table, read one entry
// per cycle through the table memory's single read port. busy drops at the
// same edge that raises done, so the next start may coincide with done.
// Commands are handled one at a time: start is ignored while busy is high.
// Reset clears the high-water mark, which empties the table at once; no
// clearing pass is needed since only slots below the mark are ever read.
module key_to_slot_id_allocator
    import kts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int EYES  = EYES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [KEY_W-1:0]      key,
    input  logic [MASK_W-1:0]     eye_mask,
    output logic                  done,
    output logic [SLOT_OUT_W-1:0] slot_id,
    output logic [COMB_OUT_W-1:0] combined_id,
    output logic                  was_present,
    output logic                  table_full,
    output logic                  release_missing
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SX_W   = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam int CW     = (SLOT_W + 5 > COMB_OUT_W) ? SLOT_W + 5 : COMB_OUT_W;

    logic                  go;
    logic                  res_valid;
    logic [SLOT_W-1:0]     res_slot;
    kts_flags_t            res_flags;

    logic [MASK_W-1:0]     mask_reg;
    logic                  done_reg;
    logic [SLOT_OUT_W-1:0] slot_id_reg, slot_id_next;
    logic [COMB_OUT_W-1:0] comb_reg, comb_next;
    logic                  present_reg, full_reg, missing_reg;

    logic [SX_W-1:0]       slot_x;
    logic [CW-1:0]         comb_full;

    assign go = start && !busy;

    kts_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .op        (opcode),
        .key       (key),
        .busy      (busy),
        .res_valid (res_valid),
        .res_slot  (res_slot),
        .res_flags (res_flags)
    );

    always_comb
    begin
        slot_x       = SX_W'(res_slot);
        slot_id_next = slot_x[SLOT_OUT_W-1:0];
        comb_full    = CW'(res_slot) * CW'(EYES) + CW'(eye_index(mask_reg));
        comb_next    = res_flags.give_id ? comb_full[COMB_OUT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mask_reg <= eye_mask;
        end
        if (res_valid)
        begin
            slot_id_reg <= slot_id_next;
            comb_reg    <= comb_next;
            present_reg <= res_flags.present;
            full_reg    <= res_flags.full;
            missing_reg <= res_flags.missing;
        end
    end

    assign done            = done_reg;
    assign slot_id         = slot_id_reg;
    assign combined_id     = comb_reg;
    assign was_present     = present_reg;
    assign table_full      = full_reg;
    assign release_missing = missing_reg;

endmodule

// File: rtl/kts_checker.sv
// Port-level checks for the key-to-slot allocator, bound to the top level.
module kts_checker
    import kts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [SLOT_OUT_W-1:0] slot_id,
    input logic [COMB_OUT_W-1:0] combined_id,
    input logic                  was_present,
    input logic                  table_full,
    input logic                  release_missing
);

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(table_full && release_missing))
        else $error("full and missing both set");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> slot_id == '0 && combined_id == '0 && !was_present)
        else $error("full result not zeroed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && release_missing |-> slot_id == '0 && combined_id == '0 && !was_present)
        else $error("missing release result not zeroed");

    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without work");

endmodule

bind key_to_slot_id_allocator kts_checker u_kts_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the key-to-slot allocator: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
    import kts_pkg::*;

    localparam int SLOTS = 64;
    localparam int EYES  = 3;

    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam int POOL_MAX = 96;
    localparam int DRAIN_CYCLES = SLOTS + 16;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_id;
        logic [COMB_OUT_W-1:0] combined_id;
        logic                  was_present;
        logic                  table_full;
        logic                  release_missing;
    } slot_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  opcode;
    logic [KEY_W-1:0]      key;
    logic [MASK_W-1:0]     eye_mask;
    logic                  done;
    logic [SLOT_OUT_W-1:0] slot_id;
    logic [COMB_OUT_W-1:0] combined_id;
    logic                  was_present;
    logic                  table_full;
    logic                  release_missing;

    // predictor state
    logic [KEY_W-1:0] slot_keys [SLOTS];
    int               high_water;

    slot_result_t     expected_slots[$];
    slot_result_t     want_beat;
    logic [KEY_W-1:0] key_pool [POOL_MAX];

    int errors      = 0;
    int n_checked   = 0;
    int n_lookups   = 0;
    int n_releases  = 0;
    int n_hits      = 0;
    int n_full      = 0;
    int n_missing   = 0;
    int burst_left  = 0;

    key_to_slot_id_allocator #(
        .SLOTS (SLOTS),
        .EYES  (EYES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .key             (key),
        .eye_mask        (eye_mask),
        .done            (done),
        .slot_id         (slot_id),
        .combined_id     (combined_id),
        .was_present     (was_present),
        .table_full      (table_full),
        .release_missing (release_missing)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(50_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic slot_result_t predict_slot(input logic op, input logic [KEY_W-1:0] k,
                                                  input logic [MASK_W-1:0] m);
        slot_result_t r;
        int hit;
        int free_slot;
        int eye;
        int b;
        int i;
        r = '0;
        hit = -1;
        free_slot = -1;
        eye = 0;
        for (b = 0; b < MASK_W; b++)
            if (m[b])
                eye = b;
        for (i = 0; i < high_water; i++)
            if (hit < 0 && slot_keys[i] == k)
                hit = i;
        if (op == OP_LOOKUP)
        begin
            if (k == '0)
                r.table_full = 1'b1;
            else if (hit >= 0)
            begin
                r.was_present = 1'b1;
                r.slot_id     = SLOT_OUT_W'(hit);
                r.combined_id = COMB_OUT_W'(hit * EYES + eye);
            end
            else
            begin
                for (i = 0; i < high_water; i++)
                    if (slot_keys[i] == '0)
                        free_slot = i;
                if (free_slot < 0 && high_water < SLOTS)
                begin
                    free_slot = high_water;
                    high_water++;
                end
                if (free_slot >= 0)
                begin
                    slot_keys[free_slot] = k;
                    r.slot_id     = SLOT_OUT_W'(free_slot);
                    r.combined_id = COMB_OUT_W'(free_slot * EYES + eye);
                end
                else
                    r.table_full = 1'b1;
            end
        end
        else
        begin
            if (k != '0 && hit >= 0)
            begin
                slot_keys[hit] = '0;
                r.slot_id      = SLOT_OUT_W'(hit);
                r.was_present  = 1'b1;
            end
            else
                r.release_missing = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0)
            k = 64'd1;
        return k;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= 50)
            $display("MISMATCH beat %0d %s: got %0d, expected %0d", n_checked, what, got, want);
    endtask

    // Sender paces itself in bursts separated by idle gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [MASK_W-1:0] m, output slot_result_t res);
        @(negedge clk);
        start    <= 1'b1;
        opcode   <= op;
        key      <= k;
        eye_mask <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = predict_slot(op, k, m);
        expected_slots.push_back(res);
        if (op == OP_LOOKUP)
            n_lookups++;
        else
            n_releases++;
        n_hits    += res.was_present;
        n_full    += res.table_full;
        n_missing += res.release_missing;
        pace();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_slots.size() == 0)
                report_mismatch("beat with nothing expected, slot_id", slot_id, 0);
            else
            begin
                want_beat = expected_slots.pop_front();
                if (slot_id !== want_beat.slot_id)
                    report_mismatch("slot_id", slot_id, want_beat.slot_id);
                if (combined_id !== want_beat.combined_id)
                    report_mismatch("combined_id", combined_id, want_beat.combined_id);
                if (was_present !== want_beat.was_present)
                    report_mismatch("was_present", was_present, want_beat.was_present);
                if (table_full !== want_beat.table_full)
                    report_mismatch("table_full", table_full, want_beat.table_full);
                if (release_missing !== want_beat.release_missing)
                    report_mismatch("release_missing", release_missing,
                                    want_beat.release_missing);
            end
            n_checked++;
        end
    end

    task automatic test_directed();
        slot_result_t r;
        send_item(OP_LOOKUP,  64'h0, 3'b111, r);
        send_item(OP_RELEASE, 64'h0, 3'b000, r);
        send_item(OP_RELEASE, 64'h1, 3'b111, r);
        send_item(OP_LOOKUP,  64'h1, 3'b000, r);
        send_item(OP_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 3'b001, r);
        send_item(OP_LOOKUP,  64'h8000_0000_0000_0000, 3'b010, r);
        send_item(OP_LOOKUP,  64'h5555_5555_5555_5555, 3'b100, r);
        send_item(OP_LOOKUP,  64'hAAAA_AAAA_AAAA_AAAA, 3'b111, r);
        send_item(OP_LOOKUP,  64'h1, 3'b011, r);
        send_item(OP_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 3'b110, r);
        send_item(OP_RELEASE, 64'h8000_0000_0000_0000, 3'b101, r);
        send_item(OP_RELEASE, 64'h8000_0000_0000_0000, 3'b000, r);
        send_item(OP_LOOKUP,  64'h1234_5678_9ABC_DEF0, 3'b101, r);
        send_item(OP_RELEASE, 64'h1, 3'b010, r);
        send_item(OP_RELEASE, 64'h5555_5555_5555_5555, 3'b100, r);
        // freed slots reused highest first, then the mark grows
        send_item(OP_LOOKUP,  64'hDEAD_BEEF_0000_0001, 3'b010, r);
        send_item(OP_LOOKUP,  64'hCAFE_F00D_8000_0000, 3'b001, r);
        send_item(OP_LOOKUP,  64'h0F0F_0F0F_F0F0_F0F0, 3'b100, r);
        send_item(OP_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 3'b000, r);
        send_item(OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 3'b111, r);
        send_item(OP_LOOKUP,  64'hAAAA_AAAA_AAAA_AAAA, 3'b110, r);
    endtask

    task automatic run_churn(input int n_items, input int pool_size, input int release_pct);
        slot_result_t     r;
        logic [KEY_W-1:0] k;
        int               sel;
        int               i;
        logic             op;
        for (i = 0; i < pool_size; i++)
            key_pool[i] = fresh_key();
        for (i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
                k = '0;
            else if (sel < 9)
                k = fresh_key();
            else
                k = key_pool[$urandom_range(0, pool_size - 1)];
            op = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_LOOKUP;
            send_item(op, k, 3'($urandom_range(0, 7)), r);
        end
    endtask

    task automatic test_small_pool();
        run_churn(150, 20, 40);
    endtask

    task automatic test_full_table();
        slot_result_t     r;
        logic [KEY_W-1:0] top_key;
        int               tries;
        r = '0;
        tries = 0;
        while (!r.table_full && tries < SLOTS + 4)
        begin
            send_item(OP_LOOKUP, fresh_key(), 3'($urandom_range(0, 7)), r);
            tries++;
        end
        top_key = slot_keys[SLOTS-1];
        send_item(OP_LOOKUP, top_key, 3'b100, r);
        send_item(OP_RELEASE, top_key, 3'b011, r);
        send_item(OP_RELEASE, slot_keys[0], 3'b000, r);
        send_item(OP_LOOKUP, fresh_key(), 3'b010, r);
        send_item(OP_LOOKUP, fresh_key(), 3'b001, r);
        send_item(OP_LOOKUP, fresh_key(), 3'b111, r);
        send_item(OP_RELEASE, fresh_key(), 3'b101, r);
        send_item(OP_LOOKUP, 64'h0, 3'b100, r);
    endtask

    task automatic test_churn();
        run_churn(450, 80, 45);
    endtask

    initial
    begin
        int guard;
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_LOOKUP;
        key        = '0;
        eye_mask   = '0;
        high_water = 0;
        for (int i = 0; i < SLOTS; i++)
            slot_keys[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed();
        test_small_pool();
        test_full_table();
        test_churn();

        @(negedge clk) start <= 1'b0;
        guard = 0;
        while (expected_slots.size() != 0 && guard < 10 * DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_slots.size() != 0)
            report_mismatch("results never delivered, count", expected_slots.size(), 0);

        $display("Covered %0d lookups and %0d releases; %0d result beats checked.",
                 n_lookups, n_releases, n_checked);
        $display("Key hits/clears %0d, table-full %0d, release misses %0d, mismatches %0d.",
                 n_hits, n_full, n_missing, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
